// ===== hw/rtl/rti_pkg.sv =====
// Shared types, widths and codes for the ray/triangle intersection core.
package rti_pkg;

  localparam int COORD_BITS = 32;
  localparam int FRAC_BITS  = 16;
  localparam int TAG_BITS   = 24;

  // edge, tvec: one bit over a coordinate
  localparam int EW = COORD_BITS + 1;
  // p = dir x e2, q = tvec x e1
  localparam int PW = 2 * EW;
  localparam int QW = 2 * EW + 1;
  // partial products of the dot products: 34 x 34 bits at most
  localparam int MW = 2 * EW + 2;
  // det and the three numerators, with headroom for the three-term sums
  localparam int DW = 3 * EW + 5;
  // divider remainder: holds det << COORD_BITS
  localparam int RW = DW + COORD_BITS - 4;
  // bound compare width: quotient magnitude plus sign plus one
  localparam int SW = COORD_BITS + 2;
  // one stage for the overflow check, one per quotient bit
  localparam int DIV_STAGES = COORD_BITS + 1;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;

  localparam logic REQ_RAY = 1'b0;
  localparam logic REQ_TRI = 1'b1;

  localparam logic [1:0] ST_HIT      = 2'd0;
  localparam logic [1:0] ST_PARALLEL = 2'd1;
  localparam logic [1:0] ST_T_OUT    = 2'd2;
  localparam logic [1:0] ST_OUTSIDE  = 2'd3;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [EW-1:0]         edge_t;

  typedef struct packed {
    logic                req_type;
    coord_t              ax;
    coord_t              ay;
    coord_t              az;
    coord_t              bx;
    coord_t              by;
    coord_t              bz;
    coord_t              cx;
    coord_t              cy;
    coord_t              cz;
    logic [TAG_BITS-1:0] tri_tag;
  } rti_req_t;

  typedef struct packed {
    logic [1:0]          status;
    coord_t              hit_t;
    coord_t              bary_u;
    coord_t              bary_v;
    logic [TAG_BITS-1:0] result_tag;
  } rti_res_t;

  // triangle work item as queued between front and back
  typedef struct packed {
    edge_t [2:0]         e1;
    edge_t [2:0]         e2;
    edge_t [2:0]         tv;
    coord_t [2:0]        dv;
    coord_t              t_lo;
    coord_t              t_hi;
    logic [TAG_BITS-1:0] tag;
  } rti_work_t;

  // per-item flags that ride alongside the divider
  typedef struct packed {
    logic                par;
    logic                uv_out;
    logic [2:0]          neg;
    coord_t              t_lo;
    coord_t              t_hi;
    logic [TAG_BITS-1:0] tag;
  } rti_side_t;

endpackage

// ===== hw/rtl/rti_front.sv =====
// Front end: takes requests, holds the ray, forms edge vectors for triangles.
module rti_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  rti_pkg::rti_req_t req_data,
  input  logic              q_full,
  output logic              push,
  output rti_pkg::rti_work_t push_data
);
  import rti_pkg::*;

  coord_t ray_org [3];
  coord_t ray_dir [3];
  coord_t t_lower;
  coord_t t_upper;
  coord_t va [3];
  coord_t vb [3];
  coord_t vc [3];
  logic   acc;

  assign va[0] = req_data.ax;
  assign va[1] = req_data.ay;
  assign va[2] = req_data.az;
  assign vb[0] = req_data.bx;
  assign vb[1] = req_data.by;
  assign vb[2] = req_data.bz;
  assign vc[0] = req_data.cx;
  assign vc[1] = req_data.cy;
  assign vc[2] = req_data.cz;

  assign req_stall = q_full;
  assign acc       = req_valid && !q_full;
  assign push      = acc && (req_data.req_type == REQ_TRI);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        ray_org[i] <= '0;
        ray_dir[i] <= '0;
      end
      t_lower <= '0;
      t_upper <= '0;
    end else if (acc && (req_data.req_type == REQ_RAY)) begin
      for (int i = 0; i < 3; i++) begin
        ray_org[i] <= va[i];
        ray_dir[i] <= vb[i];
      end
      t_lower <= req_data.cx;
      t_upper <= req_data.cy;
    end
  end

  // triangles pick up the ray as it stands at acceptance
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      push_data.e1[i] = EW'(vb[i]) - EW'(va[i]);
      push_data.e2[i] = EW'(vc[i]) - EW'(va[i]);
      push_data.tv[i] = EW'(ray_org[i]) - EW'(va[i]);
      push_data.dv[i] = ray_dir[i];
    end
    push_data.t_lo = t_lower;
    push_data.t_hi = t_upper;
    push_data.tag  = req_data.tri_tag;
  end

endmodule

// ===== hw/rtl/rti_queue.sv =====
// Small FIFO of triangle work items between front and back.
module rti_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  rti_pkg::rti_work_t wdata,
  input  logic               pop,
  output rti_pkg::rti_work_t rdata,
  output logic               full,
  output logic               empty
);
  import rti_pkg::*;

  rti_work_t         mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign full  = (count == (QPTR_W + 1)'(QDEPTH));
  assign empty = (count == '0);
  assign rdata = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= wdata;
  end

endmodule

// ===== hw/rtl/rti_div.sv =====
// Pipelined restoring divider, three numerators over one shared divisor.
module rti_div (
  input  logic                                      clk,
  input  logic                                      en,
  input  logic [rti_pkg::DW-1:0]                    den,
  input  logic [2:0][rti_pkg::DW-1:0]               mag,
  output logic [2:0][rti_pkg::COORD_BITS-1:0]       quo,
  output logic [2:0]                                big,
  output logic [2:0]                                exact
);
  import rti_pkg::*;

  logic [DW-1:0]         den_s [DIV_STAGES];
  logic [RW-1:0]         rem_s [DIV_STAGES][3];
  logic [COORD_BITS-1:0] q_s   [DIV_STAGES][3];
  logic [2:0]            big_s [DIV_STAGES];
  logic [RW-1:0]         rem_nx [DIV_STAGES][3];
  logic [COORD_BITS-1:0] q_nx   [DIV_STAGES][3];
  logic [RW:0]           diff   [DIV_STAGES][3];

  // stage s resolves quotient bit DIV_STAGES-1-s against den << that bit
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      rem_nx[0][l] = '0;
      q_nx[0][l]   = '0;
      diff[0][l]   = '0;
    end
    for (int s = 1; s < DIV_STAGES; s++) begin
      for (int l = 0; l < 3; l++) begin
        diff[s][l]   = {1'b0, rem_s[s-1][l]}
                     - ((RW + 1)'(den_s[s-1]) << (DIV_STAGES - 1 - s));
        q_nx[s][l]   = q_s[s-1][l];
        q_nx[s][l][DIV_STAGES-1-s] = !diff[s][l][RW];
        rem_nx[s][l] = diff[s][l][RW] ? rem_s[s-1][l] : diff[s][l][RW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      den_s[0] <= den;
      for (int l = 0; l < 3; l++) begin
        rem_s[0][l]    <= RW'(mag[l]) << FRAC_BITS;
        q_s[0][l]      <= '0;
        // quotient of 2^COORD_BITS or more: saturates whatever the low bits
        big_s[0][l]    <= (RW'(mag[l]) << FRAC_BITS) >= (RW'(den) << COORD_BITS);
      end
      for (int s = 1; s < DIV_STAGES; s++) begin
        den_s[s] <= den_s[s-1];
        big_s[s] <= big_s[s-1];
        for (int l = 0; l < 3; l++) begin
          rem_s[s][l] <= rem_nx[s][l];
          q_s[s][l]   <= q_nx[s][l];
        end
      end
    end
  end

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      quo[l]   = q_s[DIV_STAGES-1][l];
      big[l]   = big_s[DIV_STAGES-1][l];
      exact[l] = (rem_s[DIV_STAGES-1][l] == '0);
    end
  end

endmodule

// ===== hw/rtl/rti_back.sv =====
// Back end: cross and dot products, sign fix, divide, classify, result register.
module rti_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_empty,
  input  rti_pkg::rti_work_t q_rdata,
  output logic               q_pop,
  input  logic [31:0]        det_epsilon,
  output logic               res_valid,
  input  logic               res_stall,
  output rti_pkg::rti_res_t  res_data
);
  import rti_pkg::*;

  function automatic coord_t sat_q(logic neg, logic ovf, logic [COORD_BITS-1:0] q);
    coord_t          r;
    logic [COORD_BITS:0] qe;
    qe = {1'b0, q};
    if (!neg) begin
      r = (ovf || q[COORD_BITS-1]) ? {1'b0, {(COORD_BITS-1){1'b1}}} : q;
    end else begin
      r = (ovf || (qe > {2'b01, {(COORD_BITS-1){1'b0}}}))
          ? {1'b1, {(COORD_BITS-1){1'b0}}} : -q;
    end
    return r;
  endfunction

  // exact test of nt*2^F/det against the open interval (lo, hi)
  function automatic logic t_outside(logic neg, logic ovf, logic [COORD_BITS-1:0] q,
                                     logic ex, coord_t lo, coord_t hi);
    logic signed [SW-1:0] s;
    logic signed [SW-1:0] l;
    logic signed [SW-1:0] u;
    logic                 le_l;
    logic                 ge_u;
    s = neg ? -$signed({2'b00, q}) : $signed({2'b00, q});
    l = SW'(lo);
    u = SW'(hi);
    if (ovf) begin
      le_l = neg;
      ge_u = !neg;
    end else if (!neg) begin
      le_l = (s < l) || ((s == l) && ex);
      ge_u = (s >= u);
    end else begin
      le_l = (s <= l);
      ge_u = (s > u) || ((s == u) && ex);
    end
    return le_l || ge_u;
  endfunction

  logic adv;

  // stage 1: cross-product multiplies
  logic                  v1;
  rti_work_t             s1_w;
  logic signed [PW-2:0]  s1_pm [6];
  logic signed [QW-2:0]  s1_qm [6];
  // stage 2: p and q
  logic                  v2;
  rti_work_t             s2_w;
  logic signed [PW-1:0]  s2_p [3];
  logic signed [QW-1:0]  s2_q [3];
  // stage 3: split dot-product partials (0 det, 1 nt, 2 nu, 3 nv)
  logic                  v3;
  coord_t                s3_tlo;
  coord_t                s3_thi;
  logic [TAG_BITS-1:0]   s3_tag;
  logic signed [MW-1:0]  s3_lo [4][3];
  logic signed [MW-1:0]  s3_hi [4][3];
  // stage 4: terms
  logic                  v4;
  coord_t                s4_tlo;
  coord_t                s4_thi;
  logic [TAG_BITS-1:0]   s4_tag;
  logic signed [DW-1:0]  s4_t [4][3];
  // stage 5: sums
  logic                  v5;
  coord_t                s5_tlo;
  coord_t                s5_thi;
  logic [TAG_BITS-1:0]   s5_tag;
  logic signed [DW-1:0]  s5_n [4];
  // stage 6: det made positive
  logic                  v6;
  coord_t                s6_tlo;
  coord_t                s6_thi;
  logic [TAG_BITS-1:0]   s6_tag;
  logic signed [DW-1:0]  s6_n [4];
  // stage 7: magnitudes and flags
  logic                  v7;
  rti_side_t             s7_side;
  logic [DW-1:0]         s7_det;
  logic [2:0][DW-1:0]    s7_mag;
  // divider sideband
  logic                  vd   [DIV_STAGES];
  rti_side_t             side [DIV_STAGES];

  logic [2:0][COORD_BITS-1:0] d_quo;
  logic [2:0]                 d_big;
  logic [2:0]                 d_exact;
  rti_side_t                  fin;
  rti_res_t                   res_next;
  logic signed [DW-1:0]       uv_sum;

  assign adv   = !(res_valid && res_stall);
  assign q_pop = adv && !q_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
      v7 <= 1'b0;
      for (int s = 0; s < DIV_STAGES; s++) vd[s] <= 1'b0;
      res_valid <= 1'b0;
    end else if (adv) begin
      v1 <= !q_empty;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
      v7 <= v6;
      vd[0] <= v7;
      for (int s = 1; s < DIV_STAGES; s++) vd[s] <= vd[s-1];
      res_valid <= vd[DIV_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // cross products: component c = x[a]*y[b] - x[b]*y[a]
      s1_w <= q_rdata;
      for (int c = 0; c < 3; c++) begin
        s1_pm[2*c]   <= (PW - 1)'($signed(q_rdata.dv[(c == 2) ? 0 : c + 1]))
                      * (PW - 1)'($signed(q_rdata.e2[(c == 0) ? 2 : c - 1]));
        s1_pm[2*c+1] <= (PW - 1)'($signed(q_rdata.dv[(c == 0) ? 2 : c - 1]))
                      * (PW - 1)'($signed(q_rdata.e2[(c == 2) ? 0 : c + 1]));
        s1_qm[2*c]   <= (QW - 1)'($signed(q_rdata.tv[(c == 2) ? 0 : c + 1]))
                      * (QW - 1)'($signed(q_rdata.e1[(c == 0) ? 2 : c - 1]));
        s1_qm[2*c+1] <= (QW - 1)'($signed(q_rdata.tv[(c == 0) ? 2 : c - 1]))
                      * (QW - 1)'($signed(q_rdata.e1[(c == 2) ? 0 : c + 1]));
      end

      s2_w <= s1_w;
      for (int c = 0; c < 3; c++) begin
        s2_p[c] <= PW'(s1_pm[2*c]) - PW'(s1_pm[2*c+1]);
        s2_q[c] <= QW'(s1_qm[2*c]) - QW'(s1_qm[2*c+1]);
      end

      // p and q split into an unsigned low part and a signed high part
      s3_tlo <= s2_w.t_lo;
      s3_thi <= s2_w.t_hi;
      s3_tag <= s2_w.tag;
      for (int c = 0; c < 3; c++) begin
        s3_lo[0][c] <= MW'($signed({1'b0, s2_p[c][EW-1:0]})) * MW'($signed(s2_w.e1[c]));
        s3_hi[0][c] <= MW'($signed(s2_p[c][PW-1:EW])) * MW'($signed(s2_w.e1[c]));
        s3_lo[1][c] <= MW'($signed({1'b0, s2_q[c][EW-1:0]})) * MW'($signed(s2_w.e2[c]));
        s3_hi[1][c] <= MW'($signed(s2_q[c][QW-1:EW])) * MW'($signed(s2_w.e2[c]));
        s3_lo[2][c] <= MW'($signed({1'b0, s2_p[c][EW-1:0]})) * MW'($signed(s2_w.tv[c]));
        s3_hi[2][c] <= MW'($signed(s2_p[c][PW-1:EW])) * MW'($signed(s2_w.tv[c]));
        s3_lo[3][c] <= MW'($signed({1'b0, s2_q[c][EW-1:0]})) * MW'($signed(s2_w.dv[c]));
        s3_hi[3][c] <= MW'($signed(s2_q[c][QW-1:EW])) * MW'($signed(s2_w.dv[c]));
      end

      s4_tlo <= s3_tlo;
      s4_thi <= s3_thi;
      s4_tag <= s3_tag;
      for (int d = 0; d < 4; d++) begin
        for (int c = 0; c < 3; c++) begin
          s4_t[d][c] <= (DW'(s3_hi[d][c]) <<< EW) + DW'(s3_lo[d][c]);
        end
      end

      s5_tlo <= s4_tlo;
      s5_thi <= s4_thi;
      s5_tag <= s4_tag;
      for (int d = 0; d < 4; d++) begin
        s5_n[d] <= s4_t[d][0] + s4_t[d][1] + s4_t[d][2];
      end

      s6_tlo <= s5_tlo;
      s6_thi <= s5_thi;
      s6_tag <= s5_tag;
      for (int d = 0; d < 4; d++) begin
        s6_n[d] <= s5_n[0][DW-1] ? -s5_n[d] : s5_n[d];
      end

      s7_side.par    <= ($unsigned(s6_n[0]) <= DW'(det_epsilon));
      s7_side.uv_out <= s6_n[2][DW-1] || s6_n[3][DW-1] || (uv_sum > s6_n[0]);
      s7_side.t_lo   <= s6_tlo;
      s7_side.t_hi   <= s6_thi;
      s7_side.tag    <= s6_tag;
      s7_det         <= s6_n[0];
      for (int l = 0; l < 3; l++) begin
        s7_side.neg[l] <= s6_n[l+1][DW-1];
        s7_mag[l]      <= s6_n[l+1][DW-1] ? -s6_n[l+1] : s6_n[l+1];
      end

      side[0] <= s7_side;
      for (int s = 1; s < DIV_STAGES; s++) side[s] <= side[s-1];

      res_data <= res_next;
    end
  end

  assign uv_sum = s6_n[2] + s6_n[3];

  rti_div u_div (
    .clk   (clk),
    .en    (adv),
    .den   (s7_det),
    .mag   (s7_mag),
    .quo   (d_quo),
    .big   (d_big),
    .exact (d_exact)
  );

  assign fin = side[DIV_STAGES-1];

  always_comb begin
    res_next.result_tag = fin.tag;
    if (fin.par) begin
      res_next.status = ST_PARALLEL;
      res_next.hit_t  = '0;
      res_next.bary_u = '0;
      res_next.bary_v = '0;
    end else begin
      res_next.hit_t  = sat_q(fin.neg[0], d_big[0], d_quo[0]);
      res_next.bary_u = sat_q(fin.neg[1], d_big[1], d_quo[1]);
      res_next.bary_v = sat_q(fin.neg[2], d_big[2], d_quo[2]);
      priority if (t_outside(fin.neg[0], d_big[0], d_quo[0], d_exact[0],
                             fin.t_lo, fin.t_hi)) begin
        res_next.status = ST_T_OUT;
      end else if (fin.uv_out) begin
        res_next.status = ST_OUTSIDE;
      end else begin
        res_next.status = ST_HIT;
      end
    end
  end

endmodule

// ===== hw/rtl/ray_triangle_intersect_core.sv =====
// Top level of the fixed-point ray/triangle intersection core.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+---------------------
//  request  | req_valid / req_stall     | req_data (rti_req_t)
//  result   | res_valid / res_stall     | res_data (rti_res_t)
//  config   | cfg_valid / cfg_ready     | cfg_data (det_epsilon)
//
// One request per cycle while req_stall is low. A triangle's result goes
// through the queue, 7 product/sign stages, 33 divider stages, result register.
// Ray loads update the ray at acceptance and give no result.
// res_stall with res_valid high freezes the whole back pipeline; a 4-entry queue
// keeps taking requests until it fills, then req_stall rises.
// Reset clears the ray to zero and sets det_epsilon to 1.
module ray_triangle_intersect_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  rti_pkg::rti_req_t req_data,
  output logic              res_valid,
  input  logic              res_stall,
  output rti_pkg::rti_res_t res_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [31:0]       cfg_data
);
  import rti_pkg::*;

  logic [31:0] det_epsilon;
  logic        push;
  rti_work_t   push_data;
  logic        q_full;
  logic        q_empty;
  logic        q_pop;
  rti_work_t   q_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      det_epsilon <= 32'd1;
    end else if (cfg_valid && cfg_ready) begin
      det_epsilon <= cfg_data;
    end
  end

  rti_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_data  (req_data),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  rti_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (push_data),
    .pop   (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  rti_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_empty     (q_empty),
    .q_rdata     (q_rdata),
    .q_pop       (q_pop),
    .det_epsilon (det_epsilon),
    .res_valid   (res_valid),
    .res_stall   (res_stall),
    .res_data    (res_data)
  );

endmodule
